// ----- rtl/prq_pkg.sv -----
// types, codes and defaults shared by the priority ordered task queue
package prq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_FIND   = 2'd2,
    OP_REMOVE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] task_id;
    logic [15:0] priority_req;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_task_id;
    logic [15:0] out_priority;
    logic [31:0] out_payload;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] task_id;
    logic [15:0] prio;
    logic [31:0] payload;
  } entry_t;

  typedef struct packed {
    logic load_new;
    logic from_prev;
    logic from_next;
  } cell_ctl_t;

endpackage

// ----- rtl/priority_ordered_task_queue.sv -----
// top level: control sequencer and the chain of sorted queue cells
//
// Usage:
//   A command beat is taken on req when start is high and busy is low. The
//   opcode selects insert, pop front, find by id or remove by id.
//   Every command gives exactly one result beat on rsp, marked by done for
//   a single cycle; it carries the status and the count held afterwards.
// Sequence:
//   accept edge, a compare state in which all cells compare at once, an apply
//   state; done is registered from the apply state. busy is low again in that
//   same cycle, so a new command is taken only once the last one is done. The
//   sequence is set by the registered compare flags of the cells and the
//   first-match search over them, both independent of the queue depth.
// Reset:
//   rst clears the count and the sequencer; slot contents are left as they
//   are and are never read until written.
// Stalls:
//   the receiver cannot stall; done marks each result for one cycle only, and rsp holds it until the next result.
module priority_ordered_task_queue import prq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state, state_next;
  req_t   req_q;
  logic [CW-1:0] count, count_next;
  rsp_t   rsp_q, rsp_next;
  logic   done_q;

  entry_t    ent_v  [QUEUE_DEPTH];
  cell_ctl_t ctl    [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] displace_v, hit_v, displace_up, first_hit, hit_pre;
  entry_t new_ent, sel_ent;
  logic   full, empty, found;

  assign busy    = (state != S_IDLE);
  assign done    = done_q;
  assign rsp     = rsp_q;
  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign new_ent = '{task_id: req_q.task_id, prio: req_q.priority_req,
                     payload: req_q.payload};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;
    if (i == 0) begin : g_first
      assign prev_e = new_ent;
    end else begin : g_mid
      assign prev_e = ent_v[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = ent_v[i];
    end else begin : g_body
      assign next_e = ent_v[i+1];
    end
    prq_cell u_cell (
      .clk      (clk),
      .cap      (state == S_CMP),
      .valid    (CW'(i) < count),
      .req_id   (req_q.task_id),
      .req_pri  (req_q.priority_req),
      .ctl      (ctl[i]),
      .new_ent  (new_ent),
      .prev_ent (prev_e),
      .next_ent (next_e),
      .ent      (ent_v[i]),
      .displace (displace_v[i]),
      .hit      (hit_v[i])
    );
  end

  // first match from the front, and every slot at or behind it
  assign displace_up = {displace_v[QUEUE_DEPTH-2:0], 1'b0};
  assign first_hit   = hit_v & ~(hit_v - QUEUE_DEPTH'(1));
  assign hit_pre     = hit_v | ~(hit_v - QUEUE_DEPTH'(1));
  assign found       = |hit_v;

  always_comb begin
    sel_ent = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (first_hit[i]) sel_ent = sel_ent | ent_v[i];
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    rsp_next   = rsp_q;
    for (int i = 0; i < QUEUE_DEPTH; i++) ctl[i] = '0;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_CMP;
      end
      S_CMP: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = S_IDLE;
        rsp_next   = '0;
        case (req_q.opcode)
          OP_INSERT: begin
            if (full) begin
              rsp_next.status = STAT_FULL;
            end else begin
              rsp_next.status = STAT_OK;
              count_next      = count + CW'(1);
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                ctl[i].load_new  = displace_v[i] & ~displace_up[i];
                ctl[i].from_prev = displace_v[i] & displace_up[i];
              end
            end
          end
          OP_POP: begin
            if (empty) begin
              rsp_next.status = STAT_EMPTY;
            end else begin
              rsp_next.status       = STAT_OK;
              rsp_next.out_task_id  = ent_v[0].task_id;
              rsp_next.out_priority = ent_v[0].prio;
              rsp_next.out_payload  = ent_v[0].payload;
              count_next            = count - CW'(1);
              for (int i = 0; i < QUEUE_DEPTH; i++) ctl[i].from_next = 1'b1;
            end
          end
          OP_FIND, OP_REMOVE: begin
            if (!found) begin
              rsp_next.status = STAT_NOT_FOUND;
            end else begin
              rsp_next.status       = STAT_OK;
              rsp_next.out_task_id  = sel_ent.task_id;
              rsp_next.out_priority = sel_ent.prio;
              rsp_next.out_payload  = sel_ent.payload;
              if (req_q.opcode == OP_REMOVE) begin
                count_next = count - CW'(1);
                for (int i = 0; i < QUEUE_DEPTH; i++) ctl[i].from_next = hit_pre[i];
              end
            end
          end
          default: rsp_next.status = STAT_OK;
        endcase
        rsp_next.entry_count = 7'(count_next);
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done_q <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      done_q <= (state == S_APPLY);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) req_q <= req;
    rsp_q <= rsp_next;
  end

  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_APPLY))
    else $error("result beat without an apply cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("count beyond queue depth");

  a_first_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> $onehot0(first_hit))
    else $error("more than one first match");

  a_apply_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |=> (state == S_IDLE && done))
    else $error("apply cycle not followed by result beat");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == STAT_FULL) |-> $stable(count))
    else $error("refused insert changed the count");

endmodule

// ----- rtl/prq_cell.sv -----
// one slot of the sorted chain: holds an entry, compares it and shifts to either neighbour
module prq_cell import prq_pkg::*; (
  input  logic        clk,
  input  logic        cap,
  input  logic        valid,
  input  logic [15:0] req_id,
  input  logic [15:0] req_pri,
  input  cell_ctl_t   ctl,
  input  entry_t      new_ent,
  input  entry_t      prev_ent,
  input  entry_t      next_ent,
  output entry_t      ent,
  output logic        displace,
  output logic        hit
);

  always_ff @(posedge clk) begin
    if (cap) begin
      displace <= !valid || (req_pri > ent.prio);
      hit      <= valid && (ent.task_id == req_id);
    end
    if (ctl.load_new) begin
      ent <= new_ent;
    end else if (ctl.from_prev) begin
      ent <= prev_ent;
    end else if (ctl.from_next) begin
      ent <= next_ent;
    end
  end

endmodule
